// File: design/tsjs_pkg.sv
// Shared types and constants for the three-stage no-wait job scheduler.
package tsjs_pkg;

  localparam int OUT_W      = 32;  // width of every reported time
  localparam int SVC_W      = 16;  // width of a service time register
  localparam int CNT_CFG_W  = 11;  // width of a machine count register
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WASH_TIME     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_TIME      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD_TIME     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WASH_MACHINES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_MACHINES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD_MACHINES = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_COMMIT
  } sched_state_t;

  typedef struct packed {
    logic rd;  // read the entry under the pointer
    logic wr;  // write back that entry and advance the pointer
  } ring_ctl_t;

endpackage

// File: design/three_stage_no_wait_job_scheduler.sv
// Top level of the three-stage no-wait job scheduler.
//
// Usage:
//   Input channel (in_valid / in_stall / in_last_job): each transfer is one
//   job. Result channel (out_valid / out_stall / out_*): one result per job,
//   in job order, carrying the three stage start times, the finish time, the
//   running latest finish, the batch-end mark and the sticky overflow flag.
//   Configuration (cfg_we / cfg_idx / cfg_wdata): write service times and
//   machine counts while no job is in flight; all registers reset to 1.
// Timing:
//   A job passes through accept and ring read, start alignment, then add,
//   write back and result load. The next job is taken the cycle after
//   write back, so a new job is not accepted until the last one has been
//   written back. The read, compute, write-back loop through the three ring
//   memories sets this spacing. out_valid is set at write back.
// Reset:
//   Synchronous, active low. Rings read as zero until written (a fill count
//   per ring marks written entries), so no clearing pass is needed.
// Stall:
//   The output register holds a finished result while out_stall is high; a
//   new job is still accepted and waits at write back until the slot frees.
module three_stage_no_wait_job_scheduler #(
  parameter int MAX_MACHINES = 1024,
  parameter int TIME_WIDTH   = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [tsjs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [tsjs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // job input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_last_job,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tsjs_pkg::OUT_W-1:0]        out_wash_start,
  output logic [tsjs_pkg::OUT_W-1:0]        out_dry_start,
  output logic [tsjs_pkg::OUT_W-1:0]        out_fold_start,
  output logic [tsjs_pkg::OUT_W-1:0]        out_finish_time,
  output logic [tsjs_pkg::OUT_W-1:0]        out_latest_finish,
  output logic                              out_batch_done,
  output logic                              out_time_overflow
);
  import tsjs_pkg::*;

  // Two guard bits hold the carry of a time plus up to three service times.
  localparam int XW = TIME_WIDTH + 2;

  // configuration registers
  logic [SVC_W-1:0]     wash_time_r, dry_time_r, fold_time_r;
  logic [CNT_CFG_W-1:0] wash_machines_r, dry_machines_r, fold_machines_r;

  sched_state_t state_r, state_nxt;
  ring_ctl_t    ring_ctl;
  logic         commit;

  logic [TIME_WIDTH-1:0] fw, fd, ff;
  logic [TIME_WIDTH-1:0] s0_r, s0_nxt;
  logic                  last_r;
  logic [TIME_WIDTH-1:0] max_finish_r, max_nxt;
  logic                  overflow_r, overflow_nxt;

  logic [XW-1:0] w_ext, wd_ext, wdf_ext;
  logic [XW-1:0] c1, c2, m01;
  logic [XW-1:0] s1_x, s2_x, fin_x;
  logic [TIME_WIDTH-1:0] s1_w, s2_w, fin_w;

  logic                  out_valid_r;
  logic [OUT_W-1:0]      wash_start_r, dry_start_r, fold_start_r;
  logic [OUT_W-1:0]      finish_r, latest_r;
  logic                  batch_done_r, time_ovf_r;

  // ---------------------------------------------------------------------------
  // Configuration decode
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wash_time_r     <= SVC_W'(1);
      dry_time_r      <= SVC_W'(1);
      fold_time_r     <= SVC_W'(1);
      wash_machines_r <= CNT_CFG_W'(1);
      dry_machines_r  <= CNT_CFG_W'(1);
      fold_machines_r <= CNT_CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_WASH_TIME:     wash_time_r     <= cfg_wdata[SVC_W-1:0];
        CFG_DRY_TIME:      dry_time_r      <= cfg_wdata[SVC_W-1:0];
        CFG_FOLD_TIME:     fold_time_r     <= cfg_wdata[SVC_W-1:0];
        CFG_WASH_MACHINES: wash_machines_r <= cfg_wdata[CNT_CFG_W-1:0];
        CFG_DRY_MACHINES:  dry_machines_r  <= cfg_wdata[CNT_CFG_W-1:0];
        CFG_FOLD_MACHINES: fold_machines_r <= cfg_wdata[CNT_CFG_W-1:0];
        default: ;  // unused indexes: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: accept/read, align, commit
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_CALC;
      ST_CALC:   state_nxt = ST_COMMIT;
      ST_COMMIT: if (commit) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    ring_ctl.rd = 1'b0;
    ring_ctl.wr = 1'b0;
    commit      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        ring_ctl.rd = in_valid;
      end
      ST_CALC: ;
      ST_COMMIT: begin
        // Write back only when the output slot is free or emptying now.
        commit      = !out_valid_r || !out_stall;
        ring_ctl.wr = commit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Rings of next-free times, one memory per stage
  // ---------------------------------------------------------------------------
  tsjs_ring #(.MAX_MACHINES(MAX_MACHINES), .TIME_WIDTH(TIME_WIDTH)) u_wash_ring (
    .clk(clk), .rst_n(rst_n), .cfg_count(wash_machines_r), .ctl(ring_ctl),
    .wr_data(s1_w), .rd_data(fw)
  );

  tsjs_ring #(.MAX_MACHINES(MAX_MACHINES), .TIME_WIDTH(TIME_WIDTH)) u_dry_ring (
    .clk(clk), .rst_n(rst_n), .cfg_count(dry_machines_r), .ctl(ring_ctl),
    .wr_data(s2_w), .rd_data(fd)
  );

  tsjs_ring #(.MAX_MACHINES(MAX_MACHINES), .TIME_WIDTH(TIME_WIDTH)) u_fold_ring (
    .clk(clk), .rst_n(rst_n), .cfg_count(fold_machines_r), .ctl(ring_ctl),
    .wr_data(fin_w), .rd_data(ff)
  );

  // ---------------------------------------------------------------------------
  // Start alignment: the wash start is pushed out by whichever stage is
  // busiest, with each later stage's free time pulled back by the service
  // times in front of it and floored at zero.
  // ---------------------------------------------------------------------------
  assign w_ext   = XW'(wash_time_r);
  assign wd_ext  = XW'(wash_time_r) + XW'(dry_time_r);
  assign wdf_ext = wd_ext + XW'(fold_time_r);

  always_comb begin
    c1     = (XW'(fd) >= w_ext)  ? XW'(fd) - w_ext  : '0;
    c2     = (XW'(ff) >= wd_ext) ? XW'(ff) - wd_ext : '0;
    m01    = (c1 > XW'(fw)) ? c1 : XW'(fw);
    s0_nxt = (c2 > m01) ? c2[TIME_WIDTH-1:0] : m01[TIME_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) begin
      s0_r <= s0_nxt;
    end
    if (ring_ctl.rd) begin
      last_r <= in_last_job;
    end
  end

  // ---------------------------------------------------------------------------
  // Commit: three parallel adds from the wash start. The full sum overflows
  // whenever any step does, so one carry check covers the chain.
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_x         = XW'(s0_r) + w_ext;
    s2_x         = XW'(s0_r) + wd_ext;
    fin_x        = XW'(s0_r) + wdf_ext;
    s1_w         = s1_x[TIME_WIDTH-1:0];
    s2_w         = s2_x[TIME_WIDTH-1:0];
    fin_w        = fin_x[TIME_WIDTH-1:0];
    max_nxt      = (fin_w > max_finish_r) ? fin_w : max_finish_r;
    overflow_nxt = overflow_r || (fin_x[XW-1:TIME_WIDTH] != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_finish_r <= '0;
      overflow_r   <= 1'b0;
    end else if (commit) begin
      max_finish_r <= max_nxt;
      overflow_r   <= overflow_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      wash_start_r <= OUT_W'(s0_r);
      dry_start_r  <= OUT_W'(s1_w);
      fold_start_r <= OUT_W'(s2_w);
      finish_r     <= OUT_W'(fin_w);
      latest_r     <= OUT_W'(max_nxt);
      batch_done_r <= last_r;
      time_ovf_r   <= overflow_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_wash_start    = wash_start_r;
  assign out_dry_start     = dry_start_r;
  assign out_fold_start    = fold_start_r;
  assign out_finish_time   = finish_r;
  assign out_latest_finish = latest_r;
  assign out_batch_done    = batch_done_r;
  assign out_time_overflow = time_ovf_r;

endmodule

// File: design/tsjs_ring.sv
// One stage's ring of machine next-free times, held in a synchronous memory.
module tsjs_ring #(
  parameter int MAX_MACHINES = 1024,
  parameter int TIME_WIDTH   = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [tsjs_pkg::CNT_CFG_W-1:0]   cfg_count,
  input  tsjs_pkg::ring_ctl_t              ctl,
  input  logic [TIME_WIDTH-1:0]            wr_data,
  output logic [TIME_WIDTH-1:0]            rd_data
);
  import tsjs_pkg::*;

  localparam int PTR_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int CNT_W = PTR_W + 1;
  localparam int EW    = (CNT_W > CNT_CFG_W) ? CNT_W : CNT_CFG_W;

  logic [TIME_WIDTH-1:0] mem [MAX_MACHINES];

  logic [PTR_W-1:0]      ptr_r, ptr_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [PTR_W-1:0]      addr_r;
  logic [TIME_WIDTH-1:0] rdata_r;
  logic                  vld_r;

  logic [EW-1:0]    raw_ext, eff_ext;
  logic [CNT_W-1:0] cnt, cur, step;
  logic [PTR_W-1:0] rd_addr;

  // Clamp the machine count into 1..MAX_MACHINES.
  always_comb begin
    raw_ext = EW'(cfg_count);
    if (raw_ext == '0) begin
      eff_ext = EW'(1);
    end else if (raw_ext > EW'(MAX_MACHINES)) begin
      eff_ext = EW'(MAX_MACHINES);
    end else begin
      eff_ext = raw_ext;
    end
    cnt = CNT_W'(eff_ext);
  end

  // Restart the pointer when the count is no longer above it.
  assign cur     = (CNT_W'(ptr_r) >= cnt) ? '0 : CNT_W'(ptr_r);
  assign rd_addr = cur[PTR_W-1:0];
  assign step    = CNT_W'(addr_r) + CNT_W'(1);

  // Written entries always form a prefix, so a fill count marks them.
  always_comb begin
    ptr_nxt  = (step >= cnt) ? '0 : step[PTR_W-1:0];
    fill_nxt = (CNT_W'(addr_r) >= fill_r) ? step : fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
    end else if (ctl.wr) begin
      ptr_r  <= ptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      addr_r  <= rd_addr;
      rdata_r <= mem[rd_addr];
      vld_r   <= (cur < fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr_r] <= wr_data;
    end
  end

  assign rd_data = vld_r ? rdata_r : '0;

endmodule

// File: design/tsjs_chk.sv
// Port-level checks for the job scheduler, bound to the top level.
module tsjs_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [tsjs_pkg::OUT_W-1:0]  out_wash_start,
  input logic [tsjs_pkg::OUT_W-1:0]  out_finish_time,
  input logic [tsjs_pkg::OUT_W-1:0]  out_latest_finish,
  input logic                        out_time_overflow
);
  import tsjs_pkg::*;

  logic ovf_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_seen_r <= 1'b0;
    end else if (out_valid && !out_stall && out_time_overflow) begin
      ovf_seen_r <= 1'b1;
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_wash_start)
      && $stable(out_finish_time))
    else $error("stalled result changed");

  // One job at a time: an input transfer is followed by a stall.
  a_one_job: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("job accepted while another is in flight");

  // The running maximum covers the current finish time.
  a_latest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_latest_finish >= out_finish_time)
    else $error("latest finish below finish time");

  // Overflow, once reported, stays set.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ovf_seen_r |-> out_time_overflow)
    else $error("overflow flag dropped");

endmodule

bind three_stage_no_wait_job_scheduler tsjs_chk u_tsjs_chk (.*);

// File: tb/tb_three_stage_no_wait_job_scheduler.sv
// Self-checking testbench for the three-stage no-wait job scheduler.
`timescale 1ns / 100ps

module tb_three_stage_no_wait_job_scheduler;
  import tsjs_pkg::*;

  // Ring depth of the block and of the local schedule tracker.
  localparam int MAX_M = 1024;
  // Idle cycles, with no transfer on either side, after which the run is
  // declared hung. The slowest legal stretch is the long result hold-off
  // (LONG_HOLD) plus a drain and six register writes, far below this.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to let pass once the last expected result is in, before a
  // register write and before the final verdict.
  localparam int SETTLE = 6;
  // Result count at which the receiver backs off for a long stretch.
  localparam int HOLD_AT   = 160;
  localparam int LONG_HOLD = 80;

  typedef struct packed {
    logic [OUT_W-1:0] wash_start;
    logic [OUT_W-1:0] dry_start;
    logic [OUT_W-1:0] fold_start;
    logic [OUT_W-1:0] finish_time;
    logic [OUT_W-1:0] latest_finish;
    logic             batch_done;
    logic             time_overflow;
  } job_result_t;

  // One row of the directed table: register values in force for the job,
  // the job itself and, for rows simple enough to work out by hand, the
  // result typed in.
  typedef struct {
    logic [5:0][CFG_DATA_W-1:0] regs;
    logic                       last;
    bit                         typed;
    job_result_t                want;
  } job_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic in_last_job;
  logic out_valid;
  logic out_stall;
  logic [OUT_W-1:0] out_wash_start;
  logic [OUT_W-1:0] out_dry_start;
  logic [OUT_W-1:0] out_fold_start;
  logic [OUT_W-1:0] out_finish_time;
  logic [OUT_W-1:0] out_latest_finish;
  logic out_batch_done;
  logic out_time_overflow;

  three_stage_no_wait_job_scheduler u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_last_job       (in_last_job),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_wash_start    (out_wash_start),
    .out_dry_start     (out_dry_start),
    .out_fold_start    (out_fold_start),
    .out_finish_time   (out_finish_time),
    .out_latest_finish (out_latest_finish),
    .out_batch_done    (out_batch_done),
    .out_time_overflow (out_time_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Schedule tracker: our own copy of the registers and of the machine
  // free-time rings, advanced once per accepted job.
  // ---------------------------------------------------------------------
  logic [SVC_W-1:0]     wash_t, dry_t, fold_t;
  logic [CNT_CFG_W-1:0] wash_cnt, dry_cnt, fold_cnt;
  logic [OUT_W-1:0]     wash_avail [MAX_M];
  logic [OUT_W-1:0]     dry_avail  [MAX_M];
  logic [OUT_W-1:0]     fold_avail [MAX_M];
  int unsigned          wash_ptr, dry_ptr, fold_ptr;
  logic [OUT_W-1:0]     latest;
  logic                 time_wrapped;

  job_result_t expected_q [$];  // schedules of accepted jobs, oldest first
  job_row_t    job_plan [$];    // directed table
  int          mismatches;
  int          send_run;        // jobs left in a no-gap stretch, sender
  int          take_run;        // results left in a no-stall stretch, receiver

  // A count of zero means one machine; anything past the ring depth clamps.
  function automatic int unsigned machines_in_use(input logic [CNT_CFG_W-1:0] m);
    if (m == 0) return 1;
    if (m > MAX_M) return MAX_M;
    return m;
  endfunction

  // Add a service time; a carry out of the time range sets the sticky flag
  // and the sum wraps.
  function automatic logic [OUT_W-1:0] time_add(input logic [OUT_W-1:0] a,
                                                input logic [SVC_W-1:0] b);
    logic [OUT_W:0] s;
    s = {1'b0, a} + {{(OUT_W + 1 - SVC_W){1'b0}}, b};
    if (s[OUT_W]) time_wrapped = 1'b1;
    return s[OUT_W-1:0];
  endfunction

  function automatic job_result_t schedule_job(input logic last);
    int unsigned     nw, nd, nf;
    longint unsigned fw, fd, ff, c, s0;
    logic [OUT_W-1:0] s1, s2, fin;
    job_result_t     r;
    nw = machines_in_use(wash_cnt);
    nd = machines_in_use(dry_cnt);
    nf = machines_in_use(fold_cnt);
    // A count lowered since the last job can leave a pointer out of range.
    if (wash_ptr >= nw) wash_ptr = 0;
    if (dry_ptr >= nd) dry_ptr = 0;
    if (fold_ptr >= nf) fold_ptr = 0;
    fw = wash_avail[wash_ptr];
    fd = dry_avail[dry_ptr];
    ff = fold_avail[fold_ptr];
    // Earliest wash start that lets the job flow on without waiting.
    s0 = fw;
    c = (fd >= wash_t) ? fd - wash_t : 0;
    if (c > s0) s0 = c;
    c = (ff >= longint'(wash_t) + dry_t) ? ff - wash_t - dry_t : 0;
    if (c > s0) s0 = c;
    s1  = time_add(s0[OUT_W-1:0], wash_t);
    s2  = time_add(s1, dry_t);
    fin = time_add(s2, fold_t);
    wash_avail[wash_ptr] = s1;
    dry_avail[dry_ptr]   = s2;
    fold_avail[fold_ptr] = fin;
    wash_ptr = (wash_ptr + 1 >= nw) ? 0 : wash_ptr + 1;
    dry_ptr  = (dry_ptr + 1 >= nd) ? 0 : dry_ptr + 1;
    fold_ptr = (fold_ptr + 1 >= nf) ? 0 : fold_ptr + 1;
    if (fin > latest) latest = fin;
    r.wash_start    = s0[OUT_W-1:0];
    r.dry_start     = s1;
    r.fold_start    = s2;
    r.finish_time   = fin;
    r.latest_finish = latest;
    r.batch_done    = last;
    r.time_overflow = time_wrapped;
    return r;
  endfunction

  // Wait before the next transfer, drawn at random, with occasional
  // stretches of back-to-back transfers.
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      run_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_service();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CFG_DATA_W'(1);
      2: return '1;
      3: return CFG_DATA_W'($urandom_range(2, 20));
      default: return CFG_DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Machine counts: edge values, clamped values past the ring depth, and
  // junk in the bits above the register width, which the block drops.
  function automatic logic [CFG_DATA_W-1:0] pick_count_word();
    logic [CNT_CFG_W-1:0] n;
    case ($urandom_range(0, 6))
      0: n = '0;
      1: n = CNT_CFG_W'(1);
      2: n = CNT_CFG_W'(MAX_M);
      3: n = CNT_CFG_W'($urandom_range(MAX_M + 1, 2047));
      4, 5: n = CNT_CFG_W'($urandom_range(2, 8));
      default: n = CNT_CFG_W'($urandom_range(9, 300));
    endcase
    return {(CFG_DATA_W - CNT_CFG_W)'($urandom), n};
  endfunction

  function automatic void compare_field(input string name, input logic [OUT_W-1:0] want,
                                        input logic [OUT_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_WASH_TIME:     wash_t   = data;
      CFG_DRY_TIME:      dry_t    = data;
      CFG_FOLD_TIME:     fold_t   = data;
      CFG_WASH_MACHINES: wash_cnt = data[CNT_CFG_W-1:0];
      CFG_DRY_MACHINES:  dry_cnt  = data[CNT_CFG_W-1:0];
      CFG_FOLD_MACHINES: fold_cnt = data[CNT_CFG_W-1:0];
      default: ;
    endcase
  endtask

  // Drop valid, drain every outstanding result, let the block settle, then
  // rewrite all six registers.
  task automatic apply_config(input logic [5:0][CFG_DATA_W-1:0] regs);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_WASH_TIME,     regs[CFG_WASH_TIME]);
    write_reg(CFG_DRY_TIME,      regs[CFG_DRY_TIME]);
    write_reg(CFG_FOLD_TIME,     regs[CFG_FOLD_TIME]);
    write_reg(CFG_WASH_MACHINES, regs[CFG_WASH_MACHINES]);
    write_reg(CFG_DRY_MACHINES,  regs[CFG_DRY_MACHINES]);
    write_reg(CFG_FOLD_MACHINES, regs[CFG_FOLD_MACHINES]);
    cfg_we <= 1'b0;
  endtask

  // Offer one job and hold it until the transfer. Valid stays up when no
  // gap is drawn, so it is never dropped and raised in the same step.
  task automatic send_job(input logic last, input bit typed, input job_result_t want);
    int          gap;
    job_result_t predicted;
    gap = draw_wait(send_run);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_last_job <= last;
    do @(posedge clk); while (!(in_valid && !in_stall));
    // The tracker advances on every job, typed rows included.
    predicted = schedule_job(last);
    expected_q.insert(expected_q.size(), typed ? want : predicted);
  endtask

  task automatic plan_job(input logic [CFG_DATA_W-1:0] wt, dt, ft, wm, dm, fm,
                          input logic last, input bit typed,
                          input logic [OUT_W-1:0] s0, s1, s2, fin, lat);
    job_row_t row;
    row.regs[CFG_WASH_TIME]     = wt;
    row.regs[CFG_DRY_TIME]      = dt;
    row.regs[CFG_FOLD_TIME]     = ft;
    row.regs[CFG_WASH_MACHINES] = wm;
    row.regs[CFG_DRY_MACHINES]  = dm;
    row.regs[CFG_FOLD_MACHINES] = fm;
    row.last  = last;
    row.typed = typed;
    row.want  = '{s0, s1, s2, fin, lat, last, 1'b0};
    job_plan.insert(job_plan.size(), row);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus: directed table, then random phases under fresh register
  // settings.
  // ---------------------------------------------------------------------
  initial begin : job_source
    logic [5:0][CFG_DATA_W-1:0] regs_now;
    job_result_t blank;

    cfg_we      <= 1'b0;
    cfg_idx     <= CFG_WASH_TIME;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    in_last_job <= 1'b0;
    rst_n       <= 1'b0;
    blank       = '0;
    mismatches  = 0;
    send_run    = 0;
    take_run    = 0;
    wash_t = 1; dry_t = 1; fold_t = 1;
    wash_cnt = 1; dry_cnt = 1; fold_cnt = 1;
    for (int i = 0; i < MAX_M; i++) begin
      wash_avail[i] = '0;
      dry_avail[i]  = '0;
      fold_avail[i] = '0;
    end
    wash_ptr = 0; dry_ptr = 0; fold_ptr = 0;
    latest = '0;
    time_wrapped = 1'b0;

    // Out of reset, one machine per stage and unit times: each job starts
    // one tick after the previous one.
    plan_job(1, 1, 1, 1, 1, 1, 1'b0, 1, 0, 1, 2, 3, 3);
    plan_job(1, 1, 1, 1, 1, 1, 1'b0, 1, 1, 2, 3, 4, 4);
    plan_job(1, 1, 1, 1, 1, 1, 1'b1, 1, 2, 3, 4, 5, 5);
    // Zero service times.
    plan_job(0, 0, 0, 1, 1, 1, 1'b0, 0, 0, 0, 0, 0, 0);
    plan_job(0, 0, 0, 1, 1, 1, 1'b1, 0, 0, 0, 0, 0, 0);
    plan_job(0, 0, 0, 1, 1, 1, 1'b0, 0, 0, 0, 0, 0, 0);
    // Zero machine counts, read as one machine.
    plan_job(3, 5, 7, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0, 0);
    plan_job(3, 5, 7, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0, 0);
    plan_job(3, 5, 7, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0, 0);
    plan_job(3, 5, 7, 0, 0, 0, 1'b1, 0, 0, 0, 0, 0, 0);
    // Counts past the ring depth clamp; high bits of the write are dropped.
    plan_job(16'hFFFF, 1, 16'hFFFF, 16'hFFFF, MAX_M, 16'hF801, 1'b0, 0, 0, 0, 0, 0, 0);
    plan_job(16'hFFFF, 1, 16'hFFFF, 16'hFFFF, MAX_M, 16'hF801, 1'b1, 0, 0, 0, 0, 0, 0);
    plan_job(16'hFFFF, 1, 16'hFFFF, 16'hFFFF, MAX_M, 16'hF801, 1'b0, 0, 0, 0, 0, 0, 0);
    plan_job(16'hFFFF, 1, 16'hFFFF, 16'hFFFF, MAX_M, 16'hF801, 1'b0, 0, 0, 0, 0, 0, 0);
    // Wash and dry counts lowered below the pointers left by the previous rows.
    plan_job(2, 9, 4, 3, 2, 1, 1'b0, 0, 0, 0, 0, 0, 0);
    plan_job(2, 9, 4, 3, 2, 1, 1'b0, 0, 0, 0, 0, 0, 0);
    plan_job(2, 9, 4, 3, 2, 1, 1'b1, 0, 0, 0, 0, 0, 0);
    plan_job(2, 9, 4, 3, 2, 1, 1'b0, 0, 0, 0, 0, 0, 0);
    // Largest service times everywhere.
    plan_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1, 1'b0, 0, 0, 0, 0, 0, 0);
    plan_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1, 1'b0, 0, 0, 0, 0, 0, 0);
    plan_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1, 1'b0, 0, 0, 0, 0, 0, 0);
    plan_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1, 1'b1, 0, 0, 0, 0, 0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Registers come out of reset at 1; rewrite only when a row changes them.
    regs_now = {6{CFG_DATA_W'(1)}};
    foreach (job_plan[i]) begin
      if (job_plan[i].regs != regs_now) begin
        apply_config(job_plan[i].regs);
        regs_now = job_plan[i].regs;
      end
      send_job(job_plan[i].last, job_plan[i].typed, job_plan[i].want);
    end

    // Random phases, each under a fresh register setting.
    repeat (8) begin
      regs_now[CFG_WASH_TIME]     = pick_service();
      regs_now[CFG_DRY_TIME]      = pick_service();
      regs_now[CFG_FOLD_TIME]     = pick_service();
      regs_now[CFG_WASH_MACHINES] = pick_count_word();
      regs_now[CFG_DRY_MACHINES]  = pick_count_word();
      regs_now[CFG_FOLD_MACHINES] = pick_count_word();
      apply_config(regs_now);
      repeat (100) send_job($urandom_range(0, 7) == 0, 0, blank);
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: stall at random, once for a long stretch so the block
  // backs up into its input, and check each transfer against the oldest
  // expected schedule.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int          hold;
    int          results_seen;
    job_result_t want;
    results_seen = 0;
    out_stall <= 1'b1;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = (results_seen == HOLD_AT) ? LONG_HOLD : draw_wait(take_run);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        $error("result transfer with no job outstanding");
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        compare_field("wash_start",    want.wash_start,    out_wash_start);
        compare_field("dry_start",     want.dry_start,     out_dry_start);
        compare_field("fold_start",    want.fold_start,    out_fold_start);
        compare_field("finish_time",   want.finish_time,   out_finish_time);
        compare_field("latest_finish", want.latest_finish, out_latest_finish);
        compare_field("batch_done",    want.batch_done,    out_batch_done);
        compare_field("time_overflow", want.time_overflow, out_time_overflow);
      end
    end
  end

  // Hang detector: count cycles with no transfer on either channel.
  int idle_cycles;
  initial idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
